// ===== src/disk_request_track_splitter_assert.svh =====
// Assertion macros used by the splitter RTL.
`ifndef DISK_REQUEST_TRACK_SPLITTER_ASSERT_SVH
`define DISK_REQUEST_TRACK_SPLITTER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication: whenever a holds, b holds too.
`define DTS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("splitter assertion failed");
// Next-cycle implication: whenever a holds, b holds in the next cycle.
`define DTS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("splitter assertion failed");
`else
`define DTS_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define DTS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

// ===== src/dtsplit_pkg.sv =====
`default_nettype none

package dtsplit_pkg;

    // Fixed field widths
    localparam int ADDR_W = 16;
    localparam int SPT_W  = 6;
    localparam int CNT_W  = $clog2(ADDR_W + 1);

    // Commands
    localparam logic [1:0] CMD_XFER  = 2'd0;
    localparam logic [1:0] CMD_INVAL = 2'd1;
    localparam logic [1:0] CMD_HOMED = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_PRESENT = 2'd0;
    localparam logic [1:0] REG_SPT     = 2'd1;
    localparam logic [1:0] REG_HEADS   = 2'd2;
    localparam logic [1:0] REG_CAP     = 2'd3;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ===== src/dtsplit_ifs.sv =====
`default_nettype none

// Request channel
interface dtsplit_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] start_sector;
    logic [6:0]  sector_total;
    logic        is_write;

    modport source (output valid, output cmd, output start_sector,
                    output sector_total, output is_write, input ready);
    modport sink   (input valid, input cmd, input start_sector,
                    input sector_total, input is_write, output ready);
endinterface

// Chunk result channel
interface dtsplit_chunk_if;
    logic       valid;
    logic       ready;
    logic [7:0] cylinder;
    logic       head;
    logic [5:0] first_sector;
    logic [6:0] chunk_sectors;
    logic       seek_needed;
    logic       write_chunk;
    logic       error;
    logic       last;

    modport source (output valid, output cylinder, output head, output first_sector,
                    output chunk_sectors, output seek_needed, output write_chunk,
                    output error, output last, input ready);
    modport sink   (input valid, input cylinder, input head, input first_sector,
                    input chunk_sectors, input seek_needed, input write_chunk,
                    input error, input last, output ready);
endinterface

// Configuration write channel
interface dtsplit_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/disk_request_track_splitter.sv =====
// Disk request track splitter.
// Channels: req (sink) takes a command item: transfer, invalidate cylinder
// cache or recalibrated. chunk (source) gives one item per track chunk with
// cylinder, head, 1-based first sector, count, seek flag, direction, error
// and last. cfg (sink) writes the geometry registers; it is always ready.
// Handshakes complete on a rising edge with valid and ready both high.
// Flow: a transfer runs the start address through a bit-serial divider
// (address / sectors_per_track), then registers chunks, one chunk per
// cycle while the receiver keeps ready high. A request holds the
// sequencer until its last chunk is registered. Cache commands and zero
// counts finish in the idle state as they are taken; the no-drive error
// passes through the error state, which waits for a free output register.
// req.ready is high only while the sequencer is idle. A stalled receiver
// holds the chunk output register and freezes chunk generation.
// Reset clears the cylinder cache, the sequencer and the output valid and
// loads the register defaults (no drive, 18 sectors, 2 heads, cap 18).
`default_nettype none

`include "disk_request_track_splitter_assert.svh"

module disk_request_track_splitter #(
    parameter int MAX_REQUEST = 64
) (
    input wire logic          clk,
    input wire logic          rst_n,
    dtsplit_cfg_if.sink       cfg,
    dtsplit_req_if.sink       req,
    dtsplit_chunk_if.source   chunk
);

    localparam int         LEFT_W = $clog2(MAX_REQUEST + 1);
    localparam logic [6:0] MAX7   = 7'(MAX_REQUEST);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;
    localparam logic [1:0] S_ERR  = 2'd3;

    // Geometry registers
    logic       present_reg;
    logic [5:0] spt_reg;
    logic [1:0] heads_reg;
    logic [6:0] cap_reg;

    // Sequencer and cache
    logic [1:0]        state_reg, state_next;
    logic [7:0]        known_cyl_reg, known_cyl_next;
    logic              cyl_valid_reg, cyl_valid_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [16:0]       q_reg, q_next;
    logic [5:0]        off_reg, off_next;
    logic              wr_reg, wr_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] o_cyl_reg, o_cyl_next;
    logic       o_head_reg, o_head_next;
    logic [5:0] o_first_reg, o_first_next;
    logic [6:0] o_cnt_reg, o_cnt_next;
    logic       o_seek_reg, o_seek_next;
    logic       o_wr_reg, o_wr_next;
    logic       o_err_reg, o_err_next;
    logic       o_last_reg, o_last_next;

    // Divider hookup
    logic                     div_start;
    dtsplit_pkg::div_status_t div_stat;
    logic [15:0]              div_quo;
    logic [5:0]               div_rem;

    // Effective geometry
    logic [5:0] spt_eff;
    logic       two_heads;
    logic [6:0] cap_eff;
    logic [6:0] total_sat;

    // Chunk arithmetic
    logic [6:0] room, left7, n_a, n_sel, off_sum;
    logic [7:0] cyl_cur;
    logic       hd_cur, seek_cur, wraps, out_free, req_fire;

    assign spt_eff   = (spt_reg == '0) ? 6'd1 : spt_reg;
    assign two_heads = heads_reg[1];
    assign cap_eff   = (cap_reg == '0) ? 7'd1 : ((cap_reg > MAX7) ? MAX7 : cap_reg);
    assign total_sat = (req.sector_total > MAX7) ? MAX7 : req.sector_total;

    assign room    = {1'b0, spt_eff} - {1'b0, off_reg};
    assign left7   = 7'(left_reg);
    assign n_a     = (room < left7) ? room : left7;
    assign n_sel   = (n_a < cap_eff) ? n_a : cap_eff;
    assign off_sum = {1'b0, off_reg} + n_sel;
    assign wraps   = (off_sum == {1'b0, spt_eff});

    // cylinder = q / heads, head = q % heads (heads is 2 if heads_reg[1] is set, else 1)
    assign cyl_cur  = two_heads ? q_reg[8:1] : q_reg[7:0];
    assign hd_cur   = two_heads & q_reg[0];
    assign seek_cur = !cyl_valid_reg || (known_cyl_reg != cyl_cur);

    assign out_free  = !out_valid_reg || chunk.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign div_start = req_fire && (req.cmd == dtsplit_pkg::CMD_XFER) && present_reg
                       && (req.sector_total != '0);

    dtsplit_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req.start_sector),
        .divisor   (spt_eff),
        .status    (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        known_cyl_next = known_cyl_reg;
        cyl_valid_next = cyl_valid_reg;
        left_next      = left_reg;
        q_next         = q_reg;
        off_next       = off_reg;
        wr_next        = wr_reg;
        out_valid_next = out_valid_reg && !chunk.ready;
        o_cyl_next     = o_cyl_reg;
        o_head_next    = o_head_reg;
        o_first_next   = o_first_reg;
        o_cnt_next     = o_cnt_reg;
        o_seek_next    = o_seek_reg;
        o_wr_next      = o_wr_reg;
        o_err_next     = o_err_reg;
        o_last_next    = o_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    wr_next = req.is_write;
                    case (req.cmd)
                        dtsplit_pkg::CMD_XFER:
                        begin
                            if (!present_reg)
                                state_next = S_ERR;
                            else if (req.sector_total != '0)
                            begin
                                left_next  = LEFT_W'(total_sat);
                                state_next = S_DIV;
                            end
                        end
                        dtsplit_pkg::CMD_INVAL:
                            cyl_valid_next = 1'b0;
                        dtsplit_pkg::CMD_HOMED:
                        begin
                            known_cyl_next = '0;
                            cyl_valid_next = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    q_next     = {1'b0, div_quo};
                    off_next   = div_rem;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_cyl_next     = cyl_cur;
                    o_head_next    = hd_cur;
                    o_first_next   = off_reg + 6'd1;
                    o_cnt_next     = n_sel;
                    o_seek_next    = seek_cur;
                    o_wr_next      = wr_reg;
                    o_err_next     = 1'b0;
                    o_last_next    = (left7 == n_sel);
                    known_cyl_next = cyl_cur;
                    cyl_valid_next = 1'b1;
                    left_next      = LEFT_W'(left7 - n_sel);
                    if (wraps)
                    begin
                        off_next = '0;
                        q_next   = q_reg + 17'd1;
                    end
                    else
                        off_next = off_sum[5:0];
                    if (left7 == n_sel)
                        state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_cyl_next     = '0;
                    o_head_next    = 1'b0;
                    o_first_next   = '0;
                    o_cnt_next     = '0;
                    o_seek_next    = 1'b0;
                    o_wr_next      = wr_reg;
                    o_err_next     = 1'b1;
                    o_last_next    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            known_cyl_reg <= '0;
            cyl_valid_reg <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
            present_reg   <= 1'b0;
            spt_reg       <= 6'd18;
            heads_reg     <= 2'd2;
            cap_reg       <= 7'd18;
        end
        else
        begin
            state_reg     <= state_next;
            known_cyl_reg <= known_cyl_next;
            cyl_valid_reg <= cyl_valid_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    dtsplit_pkg::REG_PRESENT: present_reg <= cfg.data[0];
                    dtsplit_pkg::REG_SPT:     spt_reg     <= cfg.data[5:0];
                    dtsplit_pkg::REG_HEADS:   heads_reg   <= cfg.data[1:0];
                    dtsplit_pkg::REG_CAP:     cap_reg     <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        off_reg     <= off_next;
        wr_reg      <= wr_next;
        o_cyl_reg   <= o_cyl_next;
        o_head_reg  <= o_head_next;
        o_first_reg <= o_first_next;
        o_cnt_reg   <= o_cnt_next;
        o_seek_reg  <= o_seek_next;
        o_wr_reg    <= o_wr_next;
        o_err_reg   <= o_err_next;
        o_last_reg  <= o_last_next;
    end

    assign chunk.valid         = out_valid_reg;
    assign chunk.cylinder      = o_cyl_reg;
    assign chunk.head          = o_head_reg;
    assign chunk.first_sector  = o_first_reg;
    assign chunk.chunk_sectors = o_cnt_reg;
    assign chunk.seek_needed   = o_seek_reg;
    assign chunk.write_chunk   = o_wr_reg;
    assign chunk.error         = o_err_reg;
    assign chunk.last          = o_last_reg;

    // A normal chunk always moves at least one sector
    `DTS_ASSERT_IMPLY(a_chunk_nonzero, clk, rst_n, chunk.valid && !chunk.error,
                      chunk.chunk_sectors != '0)
    // Error item is a lone, empty, final item
    `DTS_ASSERT_IMPLY(a_err_shape, clk, rst_n, chunk.valid && chunk.error,
                      chunk.last && (chunk.chunk_sectors == '0))
    // Track offset stays inside the track and sectors remain while chunks are cut
    `DTS_ASSERT_IMPLY(a_off_in_track, clk, rst_n, state_reg == S_EMIT,
                      (off_reg < spt_eff) && (left_reg != '0))
    // Divider is launched only when idle and is busy right after
    `DTS_ASSERT_NEXT(a_div_launch, clk, rst_n, div_start, div_stat.busy)

endmodule

`default_nettype wire

// ===== src/dtsplit_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module dtsplit_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [dtsplit_pkg::ADDR_W-1:0]  dividend,
    input  wire logic [dtsplit_pkg::SPT_W-1:0]   divisor,
    output dtsplit_pkg::div_status_t             status,
    output logic      [dtsplit_pkg::ADDR_W-1:0]  quotient,
    output logic      [dtsplit_pkg::SPT_W-1:0]   remainder
);

    logic [dtsplit_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           done_reg, done_next;
    logic [dtsplit_pkg::ADDR_W-1:0] quo_reg, quo_next;
    logic [dtsplit_pkg::SPT_W-1:0]  rem_reg, rem_next;
    logic [dtsplit_pkg::SPT_W-1:0]  div_reg, div_next;
    logic [dtsplit_pkg::SPT_W:0]    trial;
    logic                           fits;

    assign trial = {rem_reg, quo_reg[dtsplit_pkg::ADDR_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            cnt_next = dtsplit_pkg::CNT_W'(dtsplit_pkg::ADDR_W);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[dtsplit_pkg::ADDR_W-2:0], fits};
            rem_next = fits ? dtsplit_pkg::SPT_W'(trial - {1'b0, div_reg})
                            : trial[dtsplit_pkg::SPT_W-1:0];
            done_next = (cnt_reg == dtsplit_pkg::CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

`default_nettype wire
